/* design/aphs_pkg.sv */
// Shared types and constants for the address/port hash set.
// Used by aphs_mod and address_port_hash_set; depends on nothing else.
package aphs_pkg;

   // Default sizing of the bucket table.
   localparam int unsigned MAX_BUCKETS_DEF = 256;
   localparam int unsigned WAYS_DEF        = 4;

   // Field widths of the request and the response.
   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned PORT_W   = 16;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 9;

   // One stored pair: valid bit, address and port.
   localparam int unsigned ENTRY_W = 1 + ADDR_W + PORT_W;

   // Bucket count register reset value.
   localparam logic [COUNT_W-1:0] BUCKET_COUNT_RESET = 9'd256;

   // The modulo unit retires one dividend bit per cycle.
   localparam int unsigned DIV_STEPS   = ADDR_W;
   localparam int unsigned DIV_COUNT_W = $clog2(DIV_STEPS);

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_HIT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_UPDATE,
      ST_REPLY
   } state_type;

   // Command to the modulo unit.
   typedef struct packed {
      logic               start;
      logic [ADDR_W-1:0]  dividend;
      logic [COUNT_W-1:0] divisor;
   } div_cmd_type;

   // Result from the modulo unit.
   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] remainder;
   } div_rsp_type;

endpackage

/* design/address_port_hash_set.sv */
// Top level of the address/port hash set: controller, bucket memory and modulo unit.
// Depends on aphs_pkg and aphs_mod.
//
// Usage:
// The request stream carries one pair per word: address and port in tdata,
// the request kind (search, insert, delete) in tuser. Every request gives
// exactly one response word with a status in tdata.
// The bucket is (address + port) modulo the bucket count, with the sum
// wrapping at 32 bits. The modulo unit takes one cycle per dividend bit.
// One request passes from acceptance to a valid response through 32 modulo
// steps, a hand-off of the remainder, one memory read, one read-modify-write
// of the bucket row and the load of the output register.
// Requests are handled one at a time; req_tready is high only when the
// controller is idle, so the next request waits until the last response is loaded.
// After reset the bucket memory is cleared, one bucket row per cycle, all
// MAX_BUCKETS rows in turn; no request is taken during that pass, but
// bucket count writes are taken at any time.
// The response sits in an output register. A stalled receiver does not block
// the next request; only a second response waits until the first is taken.
module address_port_hash_set #(
   parameter int unsigned MAX_BUCKETS = aphs_pkg::MAX_BUCKETS_DEF,
   parameter int unsigned WAYS        = aphs_pkg::WAYS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request stream.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [47:0]                   req_tdata,  // ip_address[31:0], port_number[47:32]
   input  logic [aphs_pkg::KIND_W-1:0]   req_tuser,  // kind[1:0]
   // Response stream.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,  // status[1:0], zeros above
   // Bucket count register.
   input  logic                          csr_we,
   input  logic [aphs_pkg::COUNT_W-1:0]  csr_wdata
);
   import aphs_pkg::*;

   localparam int unsigned IDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int unsigned ROW_W = WAYS * ENTRY_W;

   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     count_ff;
   logic [IDX_W-1:0]       clear_idx_ff, clear_idx_in;
   logic [IDX_W-1:0]       bucket_ff, bucket_in;
   logic [KIND_W-1:0]      kind_ff, kind_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [PORT_W-1:0]      port_ff, port_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   logic [ROW_W-1:0]       bucket_mem [MAX_BUCKETS];
   logic [ROW_W-1:0]       rdata_ff;
   logic                   mem_re;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [ROW_W-1:0]       mem_wdata;

   logic                   accept;
   logic [COUNT_W-1:0]     divisor;
   div_cmd_type            div_cmd;
   div_rsp_type            div_rsp;

   logic [WAYS-1:0]        match;
   logic [WAYS-1:0]        free;
   logic [WAYS-1:0]        match_sel;
   logic [WAYS-1:0]        free_sel;
   logic [ROW_W-1:0]       new_row;
   logic [ENTRY_W-1:0]     new_entry;

   assign accept = req_tvalid && req_tready;

   // Divisor in use: zero counts as one, values above the table size saturate.
   always_comb begin
      if (count_ff == '0) begin
         divisor = COUNT_W'(1);
      end else if (32'(count_ff) > 32'(MAX_BUCKETS)) begin
         divisor = COUNT_W'(MAX_BUCKETS);
      end else begin
         divisor = count_ff;
      end
   end

   // The modulo unit starts on the accepted word.
   assign div_cmd.start    = accept;
   assign div_cmd.dividend = req_tdata[ADDR_W-1:0] + ADDR_W'(req_tdata[ADDR_W+PORT_W-1:ADDR_W]);
   assign div_cmd.divisor  = divisor;

   aphs_mod u_mod (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   // Per-way compare of the bucket row just read.
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         free[w]  = !rdata_ff[w*ENTRY_W + ENTRY_W - 1];
         match[w] = rdata_ff[w*ENTRY_W + ENTRY_W - 1]
                    && (rdata_ff[w*ENTRY_W + PORT_W +: ADDR_W] == addr_ff)
                    && (rdata_ff[w*ENTRY_W +: PORT_W] == port_ff);
      end
      // Lowest matching way and lowest free way.
      match_sel = match & ~(match - 1'b1);
      free_sel  = free & ~(free - 1'b1);
   end

   // Build the modified row and the status for the current request.
   always_comb begin
      new_entry = {1'b1, addr_ff, port_ff};
      new_row   = rdata_ff;
      status_in = status_ff;
      case (kind_ff)
         KIND_SEARCH: begin
            status_in = (|match) ? STATUS_HIT : STATUS_MISS;
         end
         KIND_INSERT: begin
            status_in = (|free) ? STATUS_HIT : STATUS_FULL;
            for (int w = 0; w < WAYS; w++) begin
               if (free_sel[w]) begin
                  new_row[w*ENTRY_W +: ENTRY_W] = new_entry;
               end
            end
         end
         KIND_DELETE: begin
            status_in = (|match) ? STATUS_HIT : STATUS_MISS;
            for (int w = 0; w < WAYS; w++) begin
               if (match_sel[w]) begin
                  new_row[w*ENTRY_W +: ENTRY_W] = '0;
               end
            end
         end
         default: begin
            status_in = STATUS_MISS;
         end
      endcase
   end

   // Controller: next state, memory controls and response register.
   always_comb begin
      state_in      = state_ff;
      clear_idx_in  = clear_idx_ff;
      bucket_in     = bucket_ff;
      kind_in       = kind_ff;
      addr_in       = addr_ff;
      port_in       = port_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      req_tready    = 1'b0;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = bucket_ff;
      mem_wdata     = new_row;
      case (state_ff)
         ST_CLEAR: begin
            mem_we       = 1'b1;
            mem_waddr    = clear_idx_ff;
            mem_wdata    = '0;
            clear_idx_in = clear_idx_ff + 1'b1;
            if (clear_idx_ff == IDX_W'(MAX_BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in  = req_tuser;
               addr_in  = req_tdata[ADDR_W-1:0];
               port_in  = req_tdata[ADDR_W+PORT_W-1:ADDR_W];
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               bucket_in = IDX_W'(div_rsp.remainder);
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            mem_re   = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            mem_we   = (kind_ff == KIND_INSERT) || (kind_ff == KIND_DELETE);
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers and the bucket count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= BUCKET_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
   end

   // Request and response payload registers.
   always_ff @(posedge clock) begin
      bucket_ff     <= bucket_in;
      kind_ff       <= kind_in;
      addr_ff       <= addr_in;
      port_ff       <= port_in;
      rsp_status_ff <= rsp_status_in;
      if (state_ff == ST_UPDATE) begin
         status_ff <= status_in;
      end
   end

   // Bucket memory: one row per bucket, registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bucket_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= bucket_mem[bucket_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8 - STATUS_W){1'b0}}, rsp_status_ff};

endmodule

/* design/aphs_mod.sv */
// Iterative 32-bit by 9-bit modulo unit, one restoring step per cycle.
// Depends on aphs_pkg for widths and the command/result structs.
module aphs_mod (
   input  logic                 clock,
   input  logic                 reset,
   input  aphs_pkg::div_cmd_type cmd,
   output aphs_pkg::div_rsp_type rsp
);
   import aphs_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIV_COUNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0]      quot_ff, quot_in;
   logic [COUNT_W-1:0]     rem_ff, rem_in;
   logic [COUNT_W-1:0]     div_ff, div_in;
   logic [COUNT_W:0]       trial;

   // One restoring step: shift in the next dividend bit and subtract if it fits.
   always_comb begin
      trial    = {rem_ff, quot_ff[ADDR_W-1]};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quot_in  = cmd.dividend;
         rem_in   = '0;
         div_in   = cmd.divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[ADDR_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = COUNT_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = COUNT_W'(trial);
         end
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_COUNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule
